// ===== hw/rtl/lcdseq_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Types, codes and the control store of the 4-bit character LCD write
// sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

    // Request kinds carried on the input tuser
    localparam logic [2:0] MODE_INIT   = 3'd0;
    localparam logic [2:0] MODE_CMD    = 3'd1;
    localparam logic [2:0] MODE_CHAR   = 3'd2;
    localparam logic [2:0] MODE_CURSOR = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // Controller command bytes
    localparam logic [7:0] CMD_HOME4   = 8'h02;
    localparam logic [7:0] CMD_FUNC    = 8'h28;
    localparam logic [7:0] CMD_DISPLAY = 8'h0C;
    localparam logic [7:0] CMD_ENTRY   = 8'h06;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_ROW0    = 8'h80;
    localparam logic [7:0] CMD_ROW1    = 8'hC0;
    localparam logic [7:0] MASK_LO     = 8'h0F;
    localparam logic [7:0] MASK_HI     = 8'hF0;

    // Register indexes
    localparam logic [1:0] REG_POWER_ON = 2'd0;
    localparam logic [1:0] REG_GAP      = 2'd1;
    localparam logic [1:0] REG_SETTLE   = 2'd2;
    localparam logic [1:0] REG_CLEAR    = 2'd3;

    // Program addresses
    localparam logic [2:0] PC_POWER = 3'd0;
    localparam logic [2:0] PC_BYTE  = 3'd1;

    // Init command list, last index holds the clear
    localparam logic [2:0] INIT_LAST = 3'd4;

    typedef enum logic [1:0] {
        NIB_HELD = 2'd0,
        NIB_HI   = 2'd1,
        NIB_LO   = 2'd2
    } t_nib_sel;

    typedef enum logic [1:0] {
        HOLD_ZERO   = 2'd0,
        HOLD_GAP    = 2'd1,
        HOLD_SETTLE = 2'd2,
        HOLD_POWER  = 2'd3
    } t_hold_sel;

    typedef struct packed {
        t_nib_sel  nib_sel;
        logic      rs_new;    // 0: previous RS level, 1: RS of this byte
        logic      en;
        t_hold_sel hold_sel;
        logic      end_byte;  // last step of a byte: loop or finish
    } t_ctrl;

    function automatic t_ctrl ucode(input logic [2:0] pc);
        t_ctrl w;
        w = '{NIB_HELD, 1'b0, 1'b0, HOLD_ZERO, 1'b0};
        unique case (pc)
            3'd0: w = '{NIB_HELD, 1'b0, 1'b0, HOLD_POWER,  1'b0};
            3'd1: w = '{NIB_HI,   1'b0, 1'b0, HOLD_ZERO,   1'b0};
            3'd2: w = '{NIB_HI,   1'b1, 1'b0, HOLD_ZERO,   1'b0};
            3'd3: w = '{NIB_HI,   1'b1, 1'b1, HOLD_ZERO,   1'b0};
            3'd4: w = '{NIB_HI,   1'b1, 1'b0, HOLD_GAP,    1'b0};
            3'd5: w = '{NIB_LO,   1'b1, 1'b0, HOLD_ZERO,   1'b0};
            3'd6: w = '{NIB_LO,   1'b1, 1'b1, HOLD_ZERO,   1'b0};
            3'd7: w = '{NIB_LO,   1'b1, 1'b0, HOLD_SETTLE, 1'b1};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        b = CMD_CLEAR;
        unique case (idx)
            3'd0:    b = CMD_HOME4;
            3'd1:    b = CMD_FUNC;
            3'd2:    b = CMD_DISPLAY;
            3'd3:    b = CMD_ENTRY;
            default: b = CMD_CLEAR;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/char_lcd_nibble_write_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_unit
// Turns LCD requests into timed pin states for a 4-bit character LCD bus.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+---------------------------------
//  s_axis   | in  | s_axis_tvalid/tready      | tuser mode, tdata byte/col/row
//  m_axis   | out | m_axis_tvalid/tready      | tuser rs, tdata pins+hold, tlast
//  apb      | in  | psel & penable & pwrite   | four 16-bit timing registers
//
//  A byte request is accepted, then runs 7 program steps; init runs the power
//  step, then the byte routine per init command; a request with no pin states
//  sends nothing. One control word, so one pin state, per unstalled cycle.
//  Reset clears the sequencer, the pin levels and loads the default timings.
//  A stalled output holds the step counter; input is taken only when idle.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [11:8] column, [13:12] row
    input  logic [2:0]  s_axis_tuser,   // [2:0] mode
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] data_nibble, [4] en, [21:5] hold_us
    output logic        m_axis_tuser,   // [0] rs
    output logic        m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcdseq_pkg::*;

    // timing registers
    logic [15:0] r_power_on, r_gap, r_settle, r_clear_extra;

    // sequencer
    logic        r_busy;
    logic [2:0]  r_pc;
    logic        r_init;      // running the init program
    logic [2:0]  r_init_idx;
    logic [7:0]  r_byte;
    logic        r_rs;
    logic        r_extra;     // byte is a clear: lengthen final hold
    logic [3:0]  r_nib_level;
    logic        r_sel_level;

    // output register
    logic        r_out_valid;
    logic [3:0]  r_out_nib;
    logic        r_out_rs;
    logic        r_out_en;
    logic [16:0] r_out_hold;
    logic        r_out_last;

    t_ctrl       w_ctrl;
    logic        w_in_xfer, w_advance, w_more, w_cfg_wr;
    logic [3:0]  n_nib;
    logic        n_rs;
    logic [16:0] n_hold;
    logic [2:0]  w_mode;
    logic [7:0]  w_data;
    logic [3:0]  w_col;
    logic [1:0]  w_row;

    assign w_mode = s_axis_tuser;
    assign w_data = s_axis_tdata[7:0];
    assign w_col  = s_axis_tdata[11:8];
    assign w_row  = s_axis_tdata[13:12];

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_POWER_ON: prdata = {16'd0, r_power_on};
            REG_GAP:      prdata = {16'd0, r_gap};
            REG_SETTLE:   prdata = {16'd0, r_settle};
            REG_CLEAR:    prdata = {16'd0, r_clear_extra};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_on    <= 16'd20000;
            r_gap         <= 16'd200;
            r_settle      <= 16'd2000;
            r_clear_extra <= 16'd2000;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_POWER_ON: r_power_on    <= pwdata[15:0];
                REG_GAP:      r_gap         <= pwdata[15:0];
                REG_SETTLE:   r_settle      <= pwdata[15:0];
                REG_CLEAR:    r_clear_extra <= pwdata[15:0];
            endcase
        end
    end

    // Control word for this step, decoded into one pin state
    assign w_ctrl = ucode(r_pc);

    always_comb begin
        unique case (w_ctrl.nib_sel)
            NIB_HI:  n_nib = r_byte[7:4];
            NIB_LO:  n_nib = r_byte[3:0];
            default: n_nib = r_nib_level;
        endcase
        n_rs = w_ctrl.rs_new ? r_rs : r_sel_level;
        unique case (w_ctrl.hold_sel)
            HOLD_ZERO:   n_hold = 17'd0;
            HOLD_GAP:    n_hold = {1'b0, r_gap};
            HOLD_SETTLE: n_hold = {1'b0, r_settle} + (r_extra ? {1'b0, r_clear_extra} : 17'd0);
            HOLD_POWER:  n_hold = {1'b0, r_power_on};
        endcase
    end

    // init loops back over the byte routine until the clear is sent
    assign w_more    = r_init && (r_init_idx != INIT_LAST);
    assign w_advance = r_busy && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_busy;
    assign w_in_xfer = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= PC_POWER;
            r_init      <= 1'b0;
            r_init_idx  <= 3'd0;
            r_nib_level <= 4'd0;
            r_sel_level <= 1'b0;
        end else if (w_in_xfer) begin
            r_pc       <= PC_BYTE;
            r_init     <= 1'b0;
            r_init_idx <= 3'd0;
            r_rs       <= 1'b0;
            r_extra    <= 1'b0;
            r_byte     <= w_data;
            unique case (w_mode)
                MODE_INIT: begin
                    r_busy <= 1'b1;
                    r_pc   <= PC_POWER;
                    r_init <= 1'b1;
                    r_byte <= init_byte(3'd0);
                end
                MODE_CMD: r_busy <= 1'b1;
                MODE_CHAR: begin
                    r_busy <= 1'b1;
                    r_rs   <= 1'b1;
                end
                MODE_CURSOR: begin
                    // rows two and three send nothing
                    r_busy <= !w_row[1];
                    r_byte <= (w_row[0] ? CMD_ROW1 : CMD_ROW0) | ({4'd0, w_col} & MASK_LO);
                end
                MODE_CLEAR: begin
                    r_busy  <= 1'b1;
                    r_byte  <= CMD_CLEAR;
                    r_extra <= 1'b1;
                end
                default: r_busy <= 1'b0;
            endcase
        end else if (w_advance) begin
            if (w_ctrl.end_byte) begin
                r_nib_level <= r_byte[3:0];
                r_sel_level <= r_rs;
                if (w_more) begin
                    r_pc       <= PC_BYTE;
                    r_init_idx <= r_init_idx + 3'd1;
                    r_byte     <= init_byte(r_init_idx + 3'd1);
                    r_extra    <= (r_init_idx + 3'd1) == INIT_LAST;
                end else begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_pc <= r_pc + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_nib  <= n_nib;
            r_out_rs   <= n_rs;
            r_out_en   <= w_ctrl.en;
            r_out_hold <= n_hold;
            r_out_last <= w_ctrl.end_byte && !w_more;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_hold, r_out_en, r_out_nib};
    assign m_axis_tuser  = r_out_rs;
    assign m_axis_tlast  = r_out_last;

    // strobe states carry no hold time
    a_strobe_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> (m_axis_tdata[21:5] == 17'd0))
        else $error("EN pulse with nonzero hold");

    // a request always ends on EN low
    a_last_en_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tdata[4])
        else $error("final pin state with EN high");

    a_init_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init_idx <= INIT_LAST)
        else $error("init command index out of range");

    a_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (w_mode == MODE_CMD || w_mode == MODE_CHAR))
        |=> (r_busy && r_pc == PC_BYTE))
        else $error("byte request did not start the byte routine");

endmodule
